>>> hdl/hpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hpc_pkg;

    localparam int CH_W           = 8;
    localparam int NUM_W          = 17;  // holds 510*d + hi and 60*n + d
    localparam int DEN_W          = CH_W + 1;
    localparam int Q_W            = 8;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = Q_W / DIV_STAGES;
    localparam int SECT_W         = 11;  // scaled hue n < 6*d
    localparam int CFG_IDX_W      = 3;
    localparam int CLASS_W        = 2;
    localparam int S_DATA_W       = 24;
    localparam int M_DATA_W       = 32;

    localparam logic [Q_W-1:0] HUE_HALF_TURN = 8'd180;

    localparam logic [CH_W-1:0] RST_BLACK_VALUE_MAX = 8'd70;
    localparam logic [CH_W-1:0] RST_GREEN_HUE_MIN   = 8'd35;
    localparam logic [CH_W-1:0] RST_GREEN_HUE_MAX   = 8'd95;
    localparam logic [CH_W-1:0] RST_GREEN_SAT_MIN   = 8'd40;
    localparam logic [CH_W-1:0] RST_GREEN_VALUE_MIN = 8'd40;
    localparam logic [CH_W-1:0] RST_WHITE_SAT_MAX   = 8'd60;
    localparam logic [CH_W-1:0] RST_WHITE_VALUE_MIN = 8'd170;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLACK_VALUE_MAX = 3'd0,
        CFG_GREEN_HUE_MIN   = 3'd1,
        CFG_GREEN_HUE_MAX   = 3'd2,
        CFG_GREEN_SAT_MIN   = 3'd3,
        CFG_GREEN_VALUE_MIN = 3'd4,
        CFG_WHITE_SAT_MAX   = 3'd5,
        CFG_WHITE_VALUE_MIN = 3'd6
    } cfg_idx_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_GREEN = 2'd0,
        CLASS_WHITE = 2'd1,
        CLASS_BLACK = 2'd2,
        CLASS_NOISE = 2'd3
    } pixel_class_t;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] black_value_max;
        logic [CH_W-1:0] green_hue_min;
        logic [CH_W-1:0] green_hue_max;
        logic [CH_W-1:0] green_sat_min;
        logic [CH_W-1:0] green_value_min;
        logic [CH_W-1:0] white_sat_max;
        logic [CH_W-1:0] white_value_min;
    } hpc_cfg_t;

    // travels beside the dividers
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            grey;   // max equals min
        logic            dark;   // max is zero
    } hpc_side_t;

endpackage
`default_nettype wire

>>> hdl/hpc_hsv_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hpc_hsv_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [hpc_pkg::CH_W-1:0]      blue_in,
    input  wire logic [hpc_pkg::CH_W-1:0]      green_in,
    input  wire logic [hpc_pkg::CH_W-1:0]      red_in,
    output logic                               out_valid,
    output logic [hpc_pkg::NUM_W-1:0]          num_s,
    output logic [hpc_pkg::DEN_W-1:0]          den_s,
    output logic [hpc_pkg::NUM_W-1:0]          num_h,
    output logic [hpc_pkg::DEN_W-1:0]          den_h,
    output hpc_pkg::hpc_side_t                 side
);

    // stage A: extremes and sector
    logic                          a_valid_reg;
    logic [hpc_pkg::CH_W-1:0]      a_b_reg, a_g_reg, a_r_reg, a_hi_reg, a_lo_reg;
    hpc_pkg::sector_t              a_sect_reg;
    logic [hpc_pkg::CH_W-1:0]      a_hi_next, a_lo_next;
    hpc_pkg::sector_t              a_sect_next;

    always_comb begin
        a_hi_next = blue_in;
        a_lo_next = blue_in;
        if (green_in > a_hi_next) a_hi_next = green_in;
        if (red_in > a_hi_next)   a_hi_next = red_in;
        if (green_in < a_lo_next) a_lo_next = green_in;
        if (red_in < a_lo_next)   a_lo_next = red_in;
        if (red_in == a_hi_next) begin
            a_sect_next = hpc_pkg::SECT_RED;
        end else if (green_in == a_hi_next) begin
            a_sect_next = hpc_pkg::SECT_GREEN;
        end else begin
            a_sect_next = hpc_pkg::SECT_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_b_reg    <= blue_in;
            a_g_reg    <= green_in;
            a_r_reg    <= red_in;
            a_hi_reg   <= a_hi_next;
            a_lo_reg   <= a_lo_next;
            a_sect_reg <= a_sect_next;
        end
    end

    // stage B: numerators and denominators of both divisions
    logic                             b_valid_reg;
    logic [hpc_pkg::NUM_W-1:0]        b_num_s_reg, b_num_h_reg;
    logic [hpc_pkg::DEN_W-1:0]        b_den_s_reg, b_den_h_reg;
    hpc_pkg::hpc_side_t               b_side_reg;
    logic [hpc_pkg::CH_W-1:0]         d;
    logic [hpc_pkg::SECT_W-1:0]       n, d_w, b_w, g_w, r_w;
    logic [hpc_pkg::NUM_W-1:0]        b_num_s_next, b_num_h_next, d_n, hi_n, n_n;
    hpc_pkg::hpc_side_t               b_side_next;

    always_comb begin
        d   = a_hi_reg - a_lo_reg;
        d_w = hpc_pkg::SECT_W'(d);
        b_w = hpc_pkg::SECT_W'(a_b_reg);
        g_w = hpc_pkg::SECT_W'(a_g_reg);
        r_w = hpc_pkg::SECT_W'(a_r_reg);
        case (a_sect_reg)
            hpc_pkg::SECT_RED: begin
                if (a_g_reg >= a_b_reg) begin
                    n = g_w - b_w;
                end else begin
                    n = (d_w << 2) + (d_w << 1) - (b_w - g_w);
                end
            end
            hpc_pkg::SECT_GREEN: n = (d_w << 1) + b_w - r_w;
            default:             n = (d_w << 2) + r_w - g_w;
        endcase
        d_n  = hpc_pkg::NUM_W'(d);
        hi_n = hpc_pkg::NUM_W'(a_hi_reg);
        n_n  = hpc_pkg::NUM_W'(n);
        b_num_s_next = (d_n << 9) - (d_n << 1) + hi_n;
        b_num_h_next = (n_n << 6) - (n_n << 2) + d_n;
        b_side_next.value = a_hi_reg;
        b_side_next.grey  = (d == '0);
        b_side_next.dark  = (a_hi_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_num_s_reg <= b_num_s_next;
            b_num_h_reg <= b_num_h_next;
            b_den_s_reg <= {a_hi_reg, 1'b0};
            b_den_h_reg <= {d, 1'b0};
            b_side_reg  <= b_side_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign num_s     = b_num_s_reg;
    assign den_s     = b_den_s_reg;
    assign num_h     = b_num_h_reg;
    assign den_h     = b_den_h_reg;
    assign side      = b_side_reg;

endmodule
`default_nettype wire

>>> hdl/hpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Two restoring dividers side by side; each stage settles BITS_PER_STAGE
// quotient bits. Both quotients are known to fit in Q_W bits.
module hpc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [hpc_pkg::NUM_W-1:0]     num_s,
    input  wire logic [hpc_pkg::DEN_W-1:0]     den_s,
    input  wire logic [hpc_pkg::NUM_W-1:0]     num_h,
    input  wire logic [hpc_pkg::DEN_W-1:0]     den_h,
    input  wire hpc_pkg::hpc_side_t            side_in,
    output logic                               out_valid,
    output logic [hpc_pkg::Q_W-1:0]            q_s,
    output logic [hpc_pkg::Q_W-1:0]            q_h,
    output hpc_pkg::hpc_side_t                 side_out
);

    localparam int NS = hpc_pkg::DIV_STAGES;

    logic                          valid_reg [NS];
    logic [hpc_pkg::NUM_W-1:0]     rem_s_reg [NS];
    logic [hpc_pkg::NUM_W-1:0]     rem_h_reg [NS];
    logic [hpc_pkg::DEN_W-1:0]     den_s_reg [NS];
    logic [hpc_pkg::DEN_W-1:0]     den_h_reg [NS];
    logic [hpc_pkg::Q_W-1:0]       q_s_reg   [NS];
    logic [hpc_pkg::Q_W-1:0]       q_h_reg   [NS];
    hpc_pkg::hpc_side_t            side_reg  [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic                          valid_in;
        logic [hpc_pkg::NUM_W-1:0]     rem_s_in, rem_h_in, rem_s_next, rem_h_next;
        logic [hpc_pkg::DEN_W-1:0]     den_s_in, den_h_in;
        logic [hpc_pkg::Q_W-1:0]       q_s_in, q_h_in, q_s_next, q_h_next;
        hpc_pkg::hpc_side_t            side_stage_in;

        if (j == 0) begin : g_first
            assign valid_in      = in_valid;
            assign rem_s_in      = num_s;
            assign rem_h_in      = num_h;
            assign den_s_in      = den_s;
            assign den_h_in      = den_h;
            assign q_s_in        = '0;
            assign q_h_in        = '0;
            assign side_stage_in = side_in;
        end else begin : g_rest
            assign valid_in      = valid_reg[j-1];
            assign rem_s_in      = rem_s_reg[j-1];
            assign rem_h_in      = rem_h_reg[j-1];
            assign den_s_in      = den_s_reg[j-1];
            assign den_h_in      = den_h_reg[j-1];
            assign q_s_in        = q_s_reg[j-1];
            assign q_h_in        = q_h_reg[j-1];
            assign side_stage_in = side_reg[j-1];
        end

        always_comb begin
            logic [hpc_pkg::NUM_W-1:0] trial_s;
            logic [hpc_pkg::NUM_W-1:0] trial_h;
            int                        pos;
            rem_s_next = rem_s_in;
            rem_h_next = rem_h_in;
            q_s_next   = q_s_in;
            q_h_next   = q_h_in;
            for (int k = 0; k < hpc_pkg::BITS_PER_STAGE; k++) begin
                pos     = hpc_pkg::Q_W - 1 - j * hpc_pkg::BITS_PER_STAGE - k;
                trial_s = hpc_pkg::NUM_W'(den_s_in) << pos;
                trial_h = hpc_pkg::NUM_W'(den_h_in) << pos;
                if (rem_s_next >= trial_s) begin
                    rem_s_next    = rem_s_next - trial_s;
                    q_s_next[pos] = 1'b1;
                end
                if (rem_h_next >= trial_h) begin
                    rem_h_next    = rem_h_next - trial_h;
                    q_h_next[pos] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_s_reg[j] <= rem_s_next;
                rem_h_reg[j] <= rem_h_next;
                den_s_reg[j] <= den_s_in;
                den_h_reg[j] <= den_h_in;
                q_s_reg[j]   <= q_s_next;
                q_h_reg[j]   <= q_h_next;
                side_reg[j]  <= side_stage_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign q_s       = q_s_reg[NS-1];
    assign q_h       = q_h_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
`default_nettype wire

>>> hdl/hpc_classify.sv
`timescale 1ns / 1ps
`default_nettype none
module hpc_classify (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [hpc_pkg::Q_W-1:0]       q_s,
    input  wire logic [hpc_pkg::Q_W-1:0]       q_h,
    input  wire hpc_pkg::hpc_side_t            side,
    input  wire hpc_pkg::hpc_cfg_t             cfg,
    output logic                               out_valid,
    output hpc_pkg::pixel_class_t              pixel_class,
    output logic [hpc_pkg::CH_W-1:0]           hue,
    output logic [hpc_pkg::CH_W-1:0]           sat,
    output logic [hpc_pkg::CH_W-1:0]           value
);

    logic                          valid_reg;
    hpc_pkg::pixel_class_t         class_reg, class_next;
    logic [hpc_pkg::CH_W-1:0]      hue_reg, hue_next, sat_reg, sat_next, value_reg;
    logic                          hue_ok;

    always_comb begin
        // wrap a rounded hue of 180 back to 0; grey pixels have no hue
        if (side.grey) begin
            hue_next = '0;
        end else if (q_h >= hpc_pkg::HUE_HALF_TURN) begin
            hue_next = q_h - hpc_pkg::HUE_HALF_TURN;
        end else begin
            hue_next = q_h;
        end
        sat_next = side.dark ? '0 : q_s;

        if (cfg.green_hue_min <= cfg.green_hue_max) begin
            hue_ok = (hue_next >= cfg.green_hue_min) && (hue_next <= cfg.green_hue_max);
        end else begin
            hue_ok = (hue_next <= cfg.green_hue_max) || (hue_next >= cfg.green_hue_min);
        end

        if (hue_ok && sat_next >= cfg.green_sat_min && side.value >= cfg.green_value_min) begin
            class_next = hpc_pkg::CLASS_GREEN;
        end else if (side.value >= cfg.white_value_min && sat_next <= cfg.white_sat_max) begin
            class_next = hpc_pkg::CLASS_WHITE;
        end else if (side.value <= cfg.black_value_max) begin
            class_next = hpc_pkg::CLASS_BLACK;
        end else begin
            class_next = hpc_pkg::CLASS_NOISE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            class_reg <= class_next;
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= side.value;
        end
    end

    assign out_valid   = valid_reg;
    assign pixel_class = class_reg;
    assign hue         = hue_reg;
    assign sat         = sat_reg;
    assign value       = value_reg;

endmodule
`default_nettype wire

>>> hdl/hsv_priority_pixel_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts BGR pixels to 8-bit HSV and classes each as green, white,
// black or noise, first match winning. Throughput is one pixel per clock while
// no result is held. From an accepted input transaction to m_tvalid a pixel
// passes the extremes and sector, the division operands, the two pipelined
// restoring dividers (saturation and hue, two quotient bits per stage), and hue
// wrap and classification into the output register. The whole pipeline holds
// while a result waits with m_tready low, and s_tready is high combinationally
// whenever m_tready is high or no result is held. Thresholds are written through
// the cfg port (always ready); the user must write them only while no pixel is
// in flight, which the block does not enforce, and indexes above 6 are dropped.
module hsv_priority_pixel_classifier (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // blue_in [7:0], green_in [15:8], red_in [23:16]
    input  wire logic [hpc_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pixel_class [1:0], hue_out [9:2], sat_out [17:10], value_out [25:18], zeros above
    output logic [hpc_pkg::M_DATA_W-1:0]           m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hpc_pkg::CH_W-1:0]          cfg_data
);

    logic                              en;
    hpc_pkg::hpc_cfg_t                 cfg_reg;
    logic                              fr_valid, dv_valid;
    logic [hpc_pkg::NUM_W-1:0]         num_s, num_h;
    logic [hpc_pkg::DEN_W-1:0]         den_s, den_h;
    logic [hpc_pkg::Q_W-1:0]           q_s, q_h;
    hpc_pkg::hpc_side_t                fr_side, dv_side;
    hpc_pkg::pixel_class_t             pixel_class;
    logic [hpc_pkg::CH_W-1:0]          hue, sat, value;

    // advance every stage unless a result is held
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.black_value_max <= hpc_pkg::RST_BLACK_VALUE_MAX;
            cfg_reg.green_hue_min   <= hpc_pkg::RST_GREEN_HUE_MIN;
            cfg_reg.green_hue_max   <= hpc_pkg::RST_GREEN_HUE_MAX;
            cfg_reg.green_sat_min   <= hpc_pkg::RST_GREEN_SAT_MIN;
            cfg_reg.green_value_min <= hpc_pkg::RST_GREEN_VALUE_MIN;
            cfg_reg.white_sat_max   <= hpc_pkg::RST_WHITE_SAT_MAX;
            cfg_reg.white_value_min <= hpc_pkg::RST_WHITE_VALUE_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hpc_pkg::CFG_BLACK_VALUE_MAX: cfg_reg.black_value_max <= cfg_data;
                hpc_pkg::CFG_GREEN_HUE_MIN:   cfg_reg.green_hue_min   <= cfg_data;
                hpc_pkg::CFG_GREEN_HUE_MAX:   cfg_reg.green_hue_max   <= cfg_data;
                hpc_pkg::CFG_GREEN_SAT_MIN:   cfg_reg.green_sat_min   <= cfg_data;
                hpc_pkg::CFG_GREEN_VALUE_MIN: cfg_reg.green_value_min <= cfg_data;
                hpc_pkg::CFG_WHITE_SAT_MAX:   cfg_reg.white_sat_max   <= cfg_data;
                hpc_pkg::CFG_WHITE_VALUE_MIN: cfg_reg.white_value_min <= cfg_data;
                default: ;
            endcase
        end
    end

    hpc_hsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .blue_in   (s_tdata[7:0]),
        .green_in  (s_tdata[15:8]),
        .red_in    (s_tdata[23:16]),
        .out_valid (fr_valid),
        .num_s     (num_s),
        .den_s     (den_s),
        .num_h     (num_h),
        .den_h     (den_h),
        .side      (fr_side)
    );

    hpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .num_s     (num_s),
        .den_s     (den_s),
        .num_h     (num_h),
        .den_h     (den_h),
        .side_in   (fr_side),
        .out_valid (dv_valid),
        .q_s       (q_s),
        .q_h       (q_h),
        .side_out  (dv_side)
    );

    hpc_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (dv_valid),
        .q_s         (q_s),
        .q_h         (q_h),
        .side        (dv_side),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .pixel_class (pixel_class),
        .hue         (hue),
        .sat         (sat),
        .value       (value)
    );

    assign m_tdata = {6'd0, value, sat, hue, pixel_class};

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hue < hpc_pkg::HUE_HALF_TURN))
        else $error("hue out of range");

    a_dark_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && value == '0) |-> (hue == '0 && sat == '0))
        else $error("dark pixel with non-zero hue or saturation");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result transaction changed");

endmodule
`default_nettype wire

>>> tb/hpc_result_checker.sv
`timescale 1ns / 1ps
module hpc_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hpc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hpc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpc_pkg::CH_W-1:0]       cfg_data,
    output int                             mismatches,
    output int                             pending
);

    localparam int REPORT_LIMIT = 10;
    localparam int CH_W         = hpc_pkg::CH_W;
    localparam int M_DATA_W     = hpc_pkg::M_DATA_W;

    typedef struct packed {
        logic [CH_W-1:0]       value;
        logic [CH_W-1:0]       sat;
        logic [CH_W-1:0]       hue;
        hpc_pkg::pixel_class_t cls;
    } hsv_result_t;

    hpc_pkg::hpc_cfg_t thr;
    hsv_result_t       expected_px[$];
    hsv_result_t       want;

    function automatic hsv_result_t classify_pixel(input logic [CH_W-1:0] b,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] r,
                                                   input hpc_pkg::hpc_cfg_t t);
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] d;
        int unsigned     n;
        int unsigned     h;
        int unsigned     s;
        logic            hue_hit;
        hsv_result_t     res;
        hi = b;
        lo = b;
        if (g > hi) hi = g;
        if (r > hi) hi = r;
        if (g < lo) lo = g;
        if (r < lo) lo = r;
        d = hi - lo;
        s = 0;
        h = 0;
        if (hi != 0) s = (510 * d + hi) / (2 * hi);
        if (d != 0) begin
            // n runs over 6*d for a full turn; red wins ties, then green
            if (hi == r) n = (g >= b) ? g - b : 6 * d - (b - g);
            else if (hi == g) n = 2 * d + b - r;
            else n = 4 * d + r - g;
            h = (60 * n + d) / (2 * d);
            if (h >= 180) h = h - 180;
        end
        if (t.green_hue_min <= t.green_hue_max)
            hue_hit = (h >= t.green_hue_min) && (h <= t.green_hue_max);
        else
            hue_hit = (h <= t.green_hue_max) || (h >= t.green_hue_min);
        if (hue_hit && s >= t.green_sat_min && hi >= t.green_value_min)
            res.cls = hpc_pkg::CLASS_GREEN;
        else if (hi >= t.white_value_min && s <= t.white_sat_max)
            res.cls = hpc_pkg::CLASS_WHITE;
        else if (hi <= t.black_value_max)
            res.cls = hpc_pkg::CLASS_BLACK;
        else
            res.cls = hpc_pkg::CLASS_NOISE;
        res.hue   = h[CH_W-1:0];
        res.sat   = s[CH_W-1:0];
        res.value = hi;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr.black_value_max = hpc_pkg::RST_BLACK_VALUE_MAX;
            thr.green_hue_min   = hpc_pkg::RST_GREEN_HUE_MIN;
            thr.green_hue_max   = hpc_pkg::RST_GREEN_HUE_MAX;
            thr.green_sat_min   = hpc_pkg::RST_GREEN_SAT_MIN;
            thr.green_value_min = hpc_pkg::RST_GREEN_VALUE_MIN;
            thr.white_sat_max   = hpc_pkg::RST_WHITE_SAT_MAX;
            thr.white_value_min = hpc_pkg::RST_WHITE_VALUE_MIN;
            expected_px.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hpc_pkg::CFG_BLACK_VALUE_MAX: thr.black_value_max = cfg_data;
                    hpc_pkg::CFG_GREEN_HUE_MIN:   thr.green_hue_min   = cfg_data;
                    hpc_pkg::CFG_GREEN_HUE_MAX:   thr.green_hue_max   = cfg_data;
                    hpc_pkg::CFG_GREEN_SAT_MIN:   thr.green_sat_min   = cfg_data;
                    hpc_pkg::CFG_GREEN_VALUE_MIN: thr.green_value_min = cfg_data;
                    hpc_pkg::CFG_WHITE_SAT_MAX:   thr.white_sat_max   = cfg_data;
                    hpc_pkg::CFG_WHITE_VALUE_MIN: thr.white_value_min = cfg_data;
                    default: ;  // drop writes to unused indexes
                endcase
            end
            if (s_tvalid && s_tready)
                expected_px.push_back(classify_pixel(s_tdata[7:0], s_tdata[15:8],
                                                     s_tdata[23:16], thr));
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result transaction with nothing expected, data %h",
                                 $realtime, m_tdata);
                end else begin
                    want = expected_px.pop_front();
                    if (m_tdata[1:0] !== want.cls || m_tdata[9:2] !== want.hue ||
                        m_tdata[17:10] !== want.sat || m_tdata[25:18] !== want.value ||
                        m_tdata[M_DATA_W-1:26] !== '0) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: pixel mismatch, expected class %0d hue %0d ",
                                     $realtime, want.cls, want.hue,
                                     "sat %0d value %0d, ", want.sat, want.value,
                                     "got class %0d hue %0d sat %0d ",
                                     m_tdata[1:0], m_tdata[9:2], m_tdata[17:10],
                                     "value %0d pad %h",
                                     m_tdata[25:18], m_tdata[M_DATA_W-1:26]);
                    end
                end
            end
        end
        pending = expected_px.size();
    end

endmodule

>>> tb/tb_hsv_priority_pixel_classifier.sv
`timescale 1ns / 1ps
module tb_hsv_priority_pixel_classifier;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 325;
    localparam int PIPE_LATENCY   = 7;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int CH_W           = hpc_pkg::CH_W;
    localparam int S_DATA_W       = hpc_pkg::S_DATA_W;
    localparam int M_DATA_W       = hpc_pkg::M_DATA_W;
    localparam int CFG_IDX_W      = hpc_pkg::CFG_IDX_W;
    localparam int CFG_BITS       = $bits(hpc_pkg::hpc_cfg_t);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CH_W-1:0]      cfg_data;

    int mismatch_count;
    int pending_results;
    int send_idle_pct = 23;
    int recv_idle_pct = 83;
    bit stall_request = 1'b0;
    int quiet_cycles  = 0;

    hsv_priority_pixel_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hpc_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatch_count),
        .pending    (pending_results)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            if (stall_request) begin
                m_tready = 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_request = 1'b0;
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_hsv_priority_pixel_classifier NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {r, g, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_word(input logic [S_DATA_W-1:0] px);
        send_pixel(px[7:0], px[15:8], px[23:16]);
    endtask

    // hold the input until every result is back, then let the pipe settle
    task automatic drain_pipeline();
        s_tvalid = 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_thresholds(input hpc_pkg::hpc_cfg_t t, input bit poke_unused);
        write_reg(hpc_pkg::CFG_BLACK_VALUE_MAX, t.black_value_max);
        write_reg(hpc_pkg::CFG_GREEN_HUE_MIN,   t.green_hue_min);
        write_reg(hpc_pkg::CFG_GREEN_HUE_MAX,   t.green_hue_max);
        write_reg(hpc_pkg::CFG_GREEN_SAT_MIN,   t.green_sat_min);
        write_reg(hpc_pkg::CFG_GREEN_VALUE_MIN, t.green_value_min);
        write_reg(hpc_pkg::CFG_WHITE_SAT_MAX,   t.white_sat_max);
        write_reg(hpc_pkg::CFG_WHITE_VALUE_MIN, t.white_value_min);
        if (poke_unused) write_reg(CFG_IDX_UNUSED, CH_W'($urandom));
        cfg_valid = 1'b0;
    endtask

    function automatic hpc_pkg::hpc_cfg_t thresholds_for(input int phase);
        hpc_pkg::hpc_cfg_t t;
        t = '0;
        case (phase)
            0: begin
                // wrapped hue window
                t.black_value_max = 8'd50;
                t.green_hue_min   = 8'd150;
                t.green_hue_max   = 8'd30;
                t.green_sat_min   = 8'd20;
                t.green_value_min = 8'd30;
                t.white_sat_max   = 8'd80;
                t.white_value_min = 8'd150;
            end
            1: t = '0;
            2: t = '1;  // hue bounds out of reach
            3: begin
                t = hpc_pkg::hpc_cfg_t'(CFG_BITS'({$urandom, $urandom}));
                t.green_hue_min = 8'd0;
                t.green_hue_max = 8'd179;
            end
            default: begin
                t = hpc_pkg::hpc_cfg_t'(CFG_BITS'({$urandom, $urandom}));
                t.green_hue_min = CH_W'($urandom_range(190));
                t.green_hue_max = CH_W'($urandom_range(190));
            end
        endcase
        return t;
    endfunction

    function automatic logic [S_DATA_W-1:0] random_pixel();
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] v;
        logic [CH_W-1:0] o;
        int              base;
        int              k;
        int              ch[3];
        case ($urandom_range(4))
            0: begin
                b = CH_W'($urandom);
                g = CH_W'($urandom);
                r = CH_W'($urandom);
            end
            1: begin
                // near grey
                base = $urandom_range(255);
                for (int i = 0; i < 3; i++) begin
                    k = base + int'($urandom_range(24)) - 12;
                    ch[i] = (k < 0) ? 0 : (k > 255) ? 255 : k;
                end
                b = CH_W'(ch[0]);
                g = CH_W'(ch[1]);
                r = CH_W'(ch[2]);
            end
            2: begin
                g = CH_W'($urandom_range(255, 30));
                r = CH_W'($urandom_range(g));
                b = CH_W'($urandom_range(g));
            end
            3: begin
                b = CH_W'($urandom_range(90));
                g = CH_W'($urandom_range(90));
                r = CH_W'($urandom_range(90));
            end
            default: begin
                // two channels tied
                v = CH_W'($urandom);
                o = CH_W'($urandom);
                case ($urandom_range(2))
                    0: begin b = v; g = v; r = o; end
                    1: begin g = v; r = v; b = o; end
                    default: begin b = v; r = v; g = o; end
                endcase
            end
        endcase
        return {r, g, b};
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed pixels (b, g, r) under the reset thresholds
        send_pixel(8'd0,   8'd0,   8'd0);    // all zero
        send_pixel(8'd255, 8'd255, 8'd255);  // full white
        send_pixel(8'd70,  8'd70,  8'd70);   // black edge
        send_pixel(8'd71,  8'd71,  8'd71);
        send_pixel(8'd170, 8'd170, 8'd170);  // white value edge
        send_pixel(8'd169, 8'd169, 8'd169);
        send_pixel(8'd0,   8'd0,   8'd255);  // pure red
        send_pixel(8'd0,   8'd255, 8'd0);    // pure green
        send_pixel(8'd255, 8'd0,   8'd0);    // pure blue
        send_pixel(8'd1,   8'd0,   8'd255);  // negative red hue rounding to a half turn
        send_pixel(8'd0,   8'd255, 8'd255);  // red and green tied
        send_pixel(8'd255, 8'd255, 8'd0);    // green and blue tied
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tied
        send_pixel(8'd1,   8'd2,   8'd2);    // saturation half rounds up
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd40,  8'd100, 8'd90);   // hue on the lower window edge
        send_pixel(8'd40,  8'd100, 8'd92);
        send_pixel(8'd100, 8'd90,  8'd40);   // hue on the upper window edge
        send_pixel(8'd100, 8'd89,  8'd40);
        send_pixel(8'd0,   8'd40,  8'd0);    // green value edge
        send_pixel(8'd0,   8'd39,  8'd0);
        send_pixel(8'd215, 8'd255, 8'd215);  // green saturation edge
        send_pixel(8'd216, 8'd255, 8'd216);
        send_pixel(8'd195, 8'd195, 8'd255);  // white saturation edge
        send_pixel(8'd194, 8'd194, 8'd255);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_pipeline();
            if (phase < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 83;
            end else if (phase < 4) begin
                send_idle_pct = 83;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_thresholds(thresholds_for(phase), phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    if (phase == 1 || phase == 5) stall_request = 1'b1;
                    if (phase == 3) drain_pipeline();
                end
                send_word(random_pixel());
            end
        end

        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 5) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_hsv_priority_pixel_classifier OK");
        else
            $display("tb_hsv_priority_pixel_classifier NOT OK");
        $finish;
    end

endmodule
